// ===== design/lfl_pkg.sv =====
package lfl_pkg;

  localparam int TABLE_DEPTH = 17;
  localparam int WORD_W      = 32;
  localparam int OUT_W       = 31;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int BIT_W       = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] LCG_MULT  = 32'd1664525;
  localparam logic [WORD_W-1:0] LCG_RESET = 32'h404DC89E;

  localparam logic [IDX_W-1:0] LONG_RESET  = IDX_W'(16);
  localparam logic [IDX_W-1:0] SHORT_RESET = IDX_W'(4);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_DEPTH - 1);

  // seed moduli
  localparam int MOD_A = 177;
  localparam int MOD_B = 167;
  localparam int MOD_C = 157;
  localparam int MOD_D = 147;

  // 256^n mod k for bytes 1..3 of the congruential word
  localparam int BW_A1 = 256 % MOD_A;
  localparam int BW_A2 = (BW_A1 * 256) % MOD_A;
  localparam int BW_A3 = (BW_A2 * 256) % MOD_A;
  localparam int BW_B1 = 256 % MOD_B;
  localparam int BW_B2 = (BW_B1 * 256) % MOD_B;
  localparam int BW_B3 = (BW_B2 * 256) % MOD_B;
  localparam int BW_C1 = 256 % MOD_C;
  localparam int BW_C2 = (BW_C1 * 256) % MOD_C;
  localparam int BW_C3 = (BW_C2 * 256) % MOD_C;
  localparam int BW_D1 = 256 % MOD_D;
  localparam int BW_D2 = (BW_D1 * 256) % MOD_D;
  localparam int BW_D3 = (BW_D2 * 256) % MOD_D;

  // fill recurrences
  localparam int FILL_M  = 179;
  localparam int FILL_D  = 169;
  localparam int FILL_DM = 53;

  // floor reciprocals: estimate low by at most one, fixed by one subtract
  localparam int Q_SHIFT  = 23;
  localparam int RECIP_M  = (1 << Q_SHIFT) / FILL_M;
  localparam int QD_SHIFT = 14;
  localparam int RECIP_D  = (1 << QD_SHIFT) / FILL_D;
  localparam int RECIP_S  = 18;
  localparam int RECIP_A  = (1 << RECIP_S) / MOD_A;
  localparam int RECIP_B  = (1 << RECIP_S) / MOD_B;
  localparam int RECIP_C  = (1 << RECIP_S) / MOD_C;
  localparam int RECIP_DS = (1 << RECIP_S) / MOD_D;

  typedef enum logic {
    OP_DRAW = 1'b0,
    OP_SEED = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_DIV,
    ST_LOAD,
    ST_FILL
  } state_t;

  typedef enum logic [1:0] {
    DV_FOLD,
    DV_QUOT,
    DV_REM
  } div_phase_t;

  typedef enum logic [2:0] {
    PH_MUL_AB,
    PH_MUL_C,
    PH_QUOT,
    PH_REM,
    PH_BIT
  } fill_phase_t;

  typedef struct packed {
    logic              draw_start;
    logic              seed_start;
    logic              draw_finish;
    logic              div_step;
    div_phase_t        div_phase;
    logic              fill_load;
    logic              fill_run;
    fill_phase_t       phase;
    logic              word_write;
    logic [IDX_W-1:0]  word_addr;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

  function automatic logic [IDX_W-1:0] clamp_index(logic [IDX_W-1:0] i);
    return (i > LAST_IDX) ? LAST_IDX : i;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - IDX_W'(1);
  endfunction

  function automatic logic [WORD_W-1:0] default_word(logic [IDX_W-1:0] i);
    logic [WORD_W-1:0] w;
    unique case (i)
      5'd0:    w = 32'hC5B191E9;
      5'd1:    w = 32'hF2C4A426;
      5'd2:    w = 32'hCB46D09C;
      5'd3:    w = 32'hB612EADF;
      5'd4:    w = 32'h57CE4A07;
      5'd5:    w = 32'h3963E451;
      5'd6:    w = 32'h47A6C699;
      5'd7:    w = 32'h57FA4D15;
      5'd8:    w = 32'hBDA044E7;
      5'd9:    w = 32'hD0C15F5F;
      5'd10:   w = 32'hF37E75A3;
      5'd11:   w = 32'h101A61FF;
      5'd12:   w = 32'h34A21D1D;
      5'd13:   w = 32'hF11874EE;
      5'd14:   w = 32'h70FBD4FC;
      5'd15:   w = 32'hFE7CA439;
      default: w = 32'hC47087BA;
    endcase
    return w;
  endfunction

endpackage

// ===== design/lfl_ram.sv =====
module lfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== design/lfl_datapath.sv =====
module lfl_datapath import lfl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ctl_cmd_t          cmd,
  input  logic [WORD_W-1:0] seed_value,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [OUT_W-1:0]  random_value,
  output dp_status_t        status
);

  // congruent 18-bit sum of the four bytes, weighted by 256^n mod k
  function automatic logic [17:0] fold_bytes(logic [WORD_W-1:0] x, int w1, int w2,
                                             int w3);
    return 18'(x[7:0]) + 18'(x[15:8]) * 18'(w1) + 18'(x[23:16]) * 18'(w2) +
           18'(x[31:24]) * 18'(w3);
  endfunction

  // floor quotient estimate of an 18-bit sum
  function automatic logic [10:0] recip_quot(logic [17:0] s, logic [10:0] r);
    logic [28:0] p;
    p = 29'(s) * 29'(r);
    return p[RECIP_S +: 11];
  endfunction

  // remainder from the estimate, one corrective subtract
  function automatic logic [7:0] rem_fix(logic [17:0] s, logic [10:0] q, logic [8:0] k);
    logic [17:0] r;
    r = s - 18'(q) * 18'(k);
    return (r >= 18'(k)) ? 8'(r - 18'(k)) : r[7:0];
  endfunction

  logic [WORD_W-1:0] cw;
  logic [IDX_W-1:0]  li;
  logic [IDX_W-1:0]  si;
  logic              valid [TABLE_DEPTH];
  logic              va;
  logic              vb;

  logic [17:0] fold_a, fold_b, fold_c, fold_d;
  logic [10:0] quot_a, quot_b, quot_c, quot_d;
  logic [7:0]  ra, rb, rc, rd;
  logic [7:0]  fa, fb, fc, fd;
  logic [15:0] ab;
  logic [22:0] abc;
  logic [13:0] dd;
  logic [5:0]  qd;
  logic [14:0] q;
  logic [WORD_W-1:0] acc;

  logic [WORD_W-1:0] mult_in;
  logic [WORD_W-1:0] cw_prod;
  logic [IDX_W-1:0]  li_c;
  logic [IDX_W-1:0]  si_c;
  logic [WORD_W-1:0] rd_a;
  logic [WORD_W-1:0] rd_b;
  logic [WORD_W-1:0] word_a;
  logic [WORD_W-1:0] word_b;
  logic [WORD_W-1:0] diff;
  logic [WORD_W-1:0] result;

  logic [38:0] q_prod;
  logic [22:0] q_times;
  logic [22:0] m_raw;
  logic [7:0]  m_val;
  logic [19:0] qd_prod;
  logic [13:0] d_raw;
  logic [7:0]  d_val;
  logic [15:0] dm;
  logic        fill_bit;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;

  assign mult_in = cmd.seed_start ? seed_value : cw;
  assign cw_prod = mult_in * LCG_MULT + WORD_W'(1);

  assign li_c   = clamp_index(li);
  assign si_c   = clamp_index(si);
  assign word_a = va ? rd_a : default_word(li_c);
  assign word_b = vb ? rd_b : default_word(si_c);
  assign diff   = word_a - word_b;
  assign result = diff - cw;

  // mod 179 of the triple product
  assign q_prod  = 39'(abc) * 39'(RECIP_M);
  assign q_times = 23'(q) * 23'(FILL_M);
  assign m_raw   = abc - q_times;
  assign m_val   = (m_raw >= 23'(FILL_M)) ? 8'(m_raw - 23'(FILL_M)) : m_raw[7:0];

  // mod 169 of 53*d+1
  assign qd_prod = 20'(dd) * 20'(RECIP_D);
  assign d_raw   = dd - 14'(qd) * 14'(FILL_D);
  assign d_val   = (d_raw >= 14'(FILL_D)) ? 8'(d_raw - 14'(FILL_D)) : d_raw[7:0];

  // (d*m) mod 64 >= 32 is bit 5 of the product
  assign dm       = 16'(fd) * 16'(fc);
  assign fill_bit = dm[5];

  assign ram_we    = cmd.draw_finish | cmd.word_write;
  assign ram_waddr = cmd.word_write ? cmd.word_addr : li_c;
  assign ram_wdata = cmd.word_write ? {acc[WORD_W-2:0], fill_bit} : diff;

  assign status.out_busy = out_valid & ~out_ready;

  lfl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.draw_start),
    .raddr_a (li_c),
    .raddr_b (si_c),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cw        <= LCG_RESET;
      li        <= LONG_RESET;
      si        <= SHORT_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
    end else begin
      if (cmd.draw_start || cmd.seed_start) begin
        cw <= cw_prod;
      end
      if (cmd.seed_start) begin
        li <= LONG_RESET;
        si <= SHORT_RESET;
      end else if (cmd.draw_finish) begin
        li <= step_down(li_c);
        si <= step_down(si_c);
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      if (cmd.draw_finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      va <= valid[li_c];
      vb <= valid[si_c];
    end
    if (cmd.draw_finish) begin
      random_value <= result[OUT_W-1:0];
    end
    if (cmd.div_step) begin
      unique case (cmd.div_phase)
        DV_FOLD: begin
          fold_a <= fold_bytes(cw, BW_A1, BW_A2, BW_A3);
          fold_b <= fold_bytes(cw, BW_B1, BW_B2, BW_B3);
          fold_c <= fold_bytes(cw, BW_C1, BW_C2, BW_C3);
          fold_d <= fold_bytes(cw, BW_D1, BW_D2, BW_D3);
        end
        DV_QUOT: begin
          quot_a <= recip_quot(fold_a, 11'(RECIP_A));
          quot_b <= recip_quot(fold_b, 11'(RECIP_B));
          quot_c <= recip_quot(fold_c, 11'(RECIP_C));
          quot_d <= recip_quot(fold_d, 11'(RECIP_DS));
        end
        DV_REM: begin
          ra <= rem_fix(fold_a, quot_a, 9'(MOD_A));
          rb <= rem_fix(fold_b, quot_b, 9'(MOD_B));
          rc <= rem_fix(fold_c, quot_c, 9'(MOD_C));
          rd <= rem_fix(fold_d, quot_d, 9'(MOD_D));
        end
        default: begin
        end
      endcase
    end
    if (cmd.fill_load) begin
      fa  <= ra + 8'd1;
      fb  <= rb + 8'd1;
      fc  <= rc + 8'd1;
      fd  <= rd + 8'd1;
      acc <= '0;
    end else if (cmd.fill_run) begin
      unique case (cmd.phase)
        PH_MUL_AB: begin
          ab <= 16'(fa) * 16'(fb);
          dd <= 14'(FILL_DM) * 14'(fd) + 14'd1;
        end
        PH_MUL_C: begin
          abc <= 23'(ab) * 23'(fc);
          qd  <= qd_prod[QD_SHIFT +: 6];
        end
        PH_QUOT: begin
          q  <= q_prod[Q_SHIFT +: 15];
          fd <= d_val;
        end
        PH_REM: begin
          fa <= fb;
          fb <= fc;
          fc <= m_val;
        end
        PH_BIT: begin
          acc <= {acc[WORD_W-2:0], fill_bit};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/lfl_controller.sv =====
module lfl_controller import lfl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       operation,
  input  dp_status_t status,
  output logic       in_ready,
  output ctl_cmd_t   cmd
);

  state_t           state, state_next;
  fill_phase_t      phase, phase_next;
  div_phase_t       div_phase, div_phase_next;
  logic [BIT_W-1:0] bit_cnt, bit_cnt_next;
  logic [IDX_W-1:0] word_cnt, word_cnt_next;
  logic             is_draw;
  logic             last_bit;

  assign is_draw  = (op_t'(operation) == OP_DRAW);
  assign last_bit = (bit_cnt == BIT_W'(WORD_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_MUL_AB;
      div_phase <= DV_FOLD;
      bit_cnt   <= '0;
      word_cnt  <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      div_phase <= div_phase_next;
      bit_cnt   <= bit_cnt_next;
      word_cnt  <= word_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    phase_next     = phase;
    div_phase_next = div_phase;
    bit_cnt_next   = bit_cnt;
    word_cnt_next  = word_cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (is_draw) begin
            state_next = ST_DRAW;
          end else begin
            state_next     = ST_DIV;
            div_phase_next = DV_FOLD;
          end
        end
      end
      ST_DRAW: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        unique case (div_phase)
          DV_FOLD: div_phase_next = DV_QUOT;
          DV_QUOT: div_phase_next = DV_REM;
          DV_REM:  state_next     = ST_LOAD;
          default: div_phase_next = DV_FOLD;
        endcase
      end
      ST_LOAD: begin
        state_next    = ST_FILL;
        phase_next    = PH_MUL_AB;
        bit_cnt_next  = '0;
        word_cnt_next = '0;
      end
      ST_FILL: begin
        unique case (phase)
          PH_MUL_AB: phase_next = PH_MUL_C;
          PH_MUL_C:  phase_next = PH_QUOT;
          PH_QUOT:   phase_next = PH_REM;
          PH_REM:    phase_next = PH_BIT;
          PH_BIT: begin
            phase_next   = PH_MUL_AB;
            bit_cnt_next = bit_cnt + BIT_W'(1);
            if (last_bit) begin
              word_cnt_next = word_cnt + IDX_W'(1);
              if (word_cnt == LAST_IDX) begin
                state_next = ST_IDLE;
              end
            end
          end
          default:   phase_next = PH_MUL_AB;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    cmd             = '0;
    cmd.draw_start  = (state == ST_IDLE) && in_valid && is_draw;
    cmd.seed_start  = (state == ST_IDLE) && in_valid && !is_draw;
    cmd.draw_finish = (state == ST_DRAW) && !status.out_busy;
    cmd.div_step    = (state == ST_DIV);
    cmd.div_phase   = div_phase;
    cmd.fill_load   = (state == ST_LOAD);
    cmd.fill_run    = (state == ST_FILL);
    cmd.phase       = phase;
    cmd.word_write  = (state == ST_FILL) && (phase == PH_BIT) && last_bit;
    cmd.word_addr   = word_cnt;
  end

endmodule

// ===== design/lagged_fibonacci_lcg_prng_unit.sv =====
// Combined subtractive lagged Fibonacci (lags 17 and 5) and 32-bit linear
// congruential random number generator. An item with operation 0 draws one
// 31-bit number; operation 1 reseeds from seed_value and gives no result.
// A draw: the accept edge reads both lag words from the 17-word table
// RAM (registered read) and steps the congruential word; the draw state
// then subtracts, writes back and loads the output register. It waits
// there only while a previous number still sits untaken in that register.
// A reseed forms the congruential word on accept, computes the
// remainders by 177, 167, 157 and 147 (byte fold, reciprocal quotient,
// corrected remainder), loads the recurrence, then runs each of the
// 17 x 32 table bits through the shared mod-179 and mod-169 steps. After
// reset the table reads as its default words through per-entry valid bits;
// there is no clearing pass.
module lagged_fibonacci_lcg_prng_unit import lfl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [WORD_W-1:0] seed_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OUT_W-1:0]  random_value
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: accept, draw, remainder and fill control
  lfl_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  // table, congruential word, fill arithmetic and output register
  lfl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .seed_value   (seed_value),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .random_value (random_value),
    .status       (status)
  );

endmodule

// ===== design/lfl_checker.sv =====
module lfl_checker import lfl_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             operation,
  input logic             out_valid,
  input logic             out_ready,
  input logic [OUT_W-1:0] random_value
);

  // an untaken number holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(random_value))
    else $error("output changed while stalled");

  // one item at a time
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // a draw into an empty output gives a number
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_DRAW) && !out_valid |=> ##1 out_valid)
    else $error("draw gave no number");

  // a reseed gives no number
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_SEED) && !out_valid |=> !out_valid)
    else $error("reseed gave a number");

  // a reseed keeps the input closed while it starts its remainder steps
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation == OP_SEED) |=> !in_ready ##1 !in_ready)
    else $error("reseed released input too early");

endmodule

bind lagged_fibonacci_lcg_prng_unit lfl_checker u_lfl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .operation    (operation),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .random_value (random_value)
);
